// ===== design/ept_pkg.sv =====
// Shared types, codes and constants of the edge-aligned PWM timer.
`timescale 1ns / 1ps
package ept_pkg;

	// Channel count limit and default
	localparam int DEF_CHANNELS = 8;
	localparam int MAX_CHANNELS = 8;

	// Command codes
	localparam logic [2:0] CMD_TICK  = 3'd0;
	localparam logic [2:0] CMD_START = 3'd1;
	localparam logic [2:0] CMD_STOP  = 3'd2;
	localparam logic [2:0] CMD_MODE  = 3'd3;
	localparam logic [2:0] CMD_DUTY  = 3'd4;
	localparam logic [2:0] CMD_PCT   = 3'd5;
	localparam logic [2:0] CMD_FREQ  = 3'd6;

	// Status codes
	localparam logic [1:0] ST_OK          = 2'd0;
	localparam logic [1:0] ST_BAD_CHANNEL = 2'd1;
	localparam logic [1:0] ST_BAD_SETTING = 2'd2;

	// Configuration register indexes
	localparam int CFG_IDX_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_CLK   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLK_SRC   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_MOD  = 8'd3;

	// Reset values
	localparam logic [31:0] RST_SRC_CLK  = 32'd8000000;
	localparam logic [2:0]  RST_PRESCALE = 3'd0;
	localparam logic [1:0]  RST_CLK_SRC  = 2'd1;
	localparam logic [15:0] RST_INIT_MOD = 16'hFFFF;

	// Arithmetic constants
	localparam logic [16:0] MAX_PERIOD_COUNTS = 17'd65536;
	localparam logic [15:0] MAX_16            = 16'hFFFF;
	localparam logic [7:0]  PCT_FULL          = 8'd100;
	localparam int          DIV_W             = 32;

	// Division by 100 as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^23
	localparam logic [23:0] PCT_RECIP = 24'd10737419;
	localparam int          PCT_SHIFT = 30;

	// Input transaction
	typedef struct packed {
		logic [2:0]  command;
		logic [3:0]  channel;
		logic        low_true_mode;
		logic [15:0] duty_counts;
		logic [7:0]  duty_percent;
		logic [31:0] frequency_hz;
	} ept_in_t;

	// Result transaction
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  pwm_out;
		logic [15:0] count_now;
		logic [15:0] period_now;
	} ept_out_t;

	// Controller states
	typedef enum logic {
		S_IDLE,
		S_DIV
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic start_div;
		logic apply_now;
		logic apply_div;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic needs_div;
		logic div_done;
	} dp_status_t;

endpackage

// ===== design/ept_div.sv =====
// Radix-2 restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module ept_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ept_pkg::DIV_W-1:0] dividend,
	input  logic [ept_pkg::DIV_W-1:0] divisor,
	output logic                      done,
	output logic [ept_pkg::DIV_W-1:0] quotient
);
	import ept_pkg::*;

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   rem_shift;
	logic [DIV_W:0]   rem_trial;
	logic             fits;

	// One shift-subtract step
	always_comb begin
		rem_shift = {rem_q, quo_q[DIV_W-1]};
		rem_trial = rem_shift - {1'b0, dsr_q};
		fits      = !rem_trial[DIV_W];
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Operands and partial results
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_trial[DIV_W-1:0] : rem_shift[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/ept_datapath.sv =====
// Timer state, channel registers, configuration and command execution.
`timescale 1ns / 1ps
module ept_datapath #(
	parameter int CHANNELS = ept_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ept_pkg::ept_in_t              in_data,
	input  ept_pkg::ctrl_cmd_t            cmd,
	output ept_pkg::dp_status_t           status,
	output ept_pkg::ept_out_t             result,
	input  logic                          cfg_we,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import ept_pkg::*;

	// Configuration
	logic [31:0] src_clk_q;
	logic [2:0]  presc_code_q;
	logic [1:0]  clk_src_q;

	// Timer state
	logic [15:0]         counter_q;
	logic [6:0]          presc_q;
	logic [15:0]         period_q;
	logic                running_q;
	logic [CHANNELS-1:0] en_q;
	logic [CHANNELS-1:0] low_q;
	logic [15:0]         cmp_q [CHANNELS];

	// Command held while the divider or the percent scaling works
	logic [3:0]  pend_ch_q;
	logic        pend_pct_q;
	logic [22:0] pct_prod_q;
	logic        pct_done_q;

	// Next state
	logic [15:0]         counter_d;
	logic [6:0]          presc_d;
	logic [15:0]         period_d;
	logic                running_d;
	logic [CHANNELS-1:0] en_d;
	logic [CHANNELS-1:0] low_d;
	logic [15:0]         cmp_d [CHANNELS];
	logic [1:0]          status_d;
	logic [7:0]          pwm_d;

	logic              ch_ok;
	logic [31:0]       src_shift;
	logic              freq_go;
	logic              pct_go;
	logic [22:0]       pct_product;
	logic [46:0]       pct_scaled;
	logic [16:0]       pct_quo;
	logic              div_done;
	logic [DIV_W-1:0]  quotient;
	logic [7:0]        div_pow;
	logic [6:0]        presc_last;
	logic [15:0]       cnt_adv;
	logic [15:0]       full_duty;

	// Compare value limited to period plus one
	function automatic logic [15:0] clamp_duty(input logic [16:0] d, input logic [15:0] per);
		logic [16:0] top;
		top = {1'b0, per} + 17'd1;
		return (d > top) ? top[15:0] : d[15:0];
	endfunction

	// Decode of the commands that use the divider or the percent scaling
	always_comb begin
		ch_ok       = 32'(in_data.channel) < 32'(CHANNELS);
		src_shift   = src_clk_q >> presc_code_q;
		freq_go     = (in_data.command == CMD_FREQ) && (in_data.frequency_hz != '0)
			&& (src_shift != '0);
		pct_go      = (in_data.command == CMD_PCT) && ch_ok && (in_data.duty_percent < PCT_FULL);
		pct_product = 23'({1'b0, period_q} + 17'd1) * {15'd0, in_data.duty_percent};
	end

	// Percent scaling: held product times the reciprocal of 100
	always_comb begin
		pct_scaled = {24'd0, pct_prod_q} * {23'd0, PCT_RECIP};
		pct_quo    = pct_scaled[PCT_SHIFT +: 17];
	end

	ept_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start_div && freq_go),
		.dividend (src_shift),
		.divisor  (in_data.frequency_hz),
		.done     (div_done),
		.quotient (quotient)
	);

	assign status.needs_div = freq_go || pct_go;
	assign status.div_done  = div_done || pct_done_q;

	// Tick helpers
	always_comb begin
		div_pow    = 8'd1 << presc_code_q;
		presc_last = 7'(div_pow - 8'd1);
		cnt_adv    = (counter_q >= period_q) ? 16'd0 : counter_q + 16'd1;
		full_duty  = (period_q < MAX_16) ? period_q + 16'd1 : period_q;
	end

	// Next state of one transaction
	always_comb begin
		counter_d = counter_q;
		presc_d   = presc_q;
		period_d  = period_q;
		running_d = running_q;
		en_d      = en_q;
		low_d     = low_q;
		for (int c = 0; c < CHANNELS; c++) cmp_d[c] = cmp_q[c];
		status_d  = ST_OK;

		if (cmd.apply_now) begin
			case (in_data.command)
				CMD_TICK: begin
					if (running_q) begin
						if (presc_q >= presc_last) begin
							presc_d   = '0;
							counter_d = cnt_adv;
						end else begin
							presc_d = presc_q + 7'd1;
						end
					end
				end
				CMD_START: running_d = (clk_src_q != '0);
				CMD_STOP:  running_d = 1'b0;
				CMD_MODE: begin
					if (!ch_ok) begin
						status_d = ST_BAD_CHANNEL;
					end else begin
						for (int c = 0; c < CHANNELS; c++) begin
							if (in_data.channel == 4'(c)) begin
								en_d[c]  = 1'b1;
								low_d[c] = in_data.low_true_mode;
							end
						end
					end
				end
				CMD_DUTY: begin
					if (!ch_ok) begin
						status_d = ST_BAD_CHANNEL;
					end else begin
						for (int c = 0; c < CHANNELS; c++) begin
							if (in_data.channel == 4'(c))
								cmp_d[c] = clamp_duty({1'b0, in_data.duty_counts}, period_q);
						end
					end
				end
				CMD_PCT: begin
					// below full percent takes the scaling path
					if (!ch_ok) begin
						status_d = ST_BAD_CHANNEL;
					end else if (in_data.duty_percent > PCT_FULL) begin
						status_d = ST_BAD_SETTING;
					end else begin
						for (int c = 0; c < CHANNELS; c++) begin
							if (in_data.channel == 4'(c)) cmp_d[c] = full_duty;
						end
					end
				end
				// frequency here only when zero frequency or zero prescaled clock
				CMD_FREQ: status_d = ST_BAD_SETTING;
				default:  status_d = ST_BAD_SETTING;
			endcase
		end else if (cmd.apply_div) begin
			if (pend_pct_q) begin
				for (int c = 0; c < CHANNELS; c++) begin
					if (pend_ch_q == 4'(c)) cmp_d[c] = clamp_duty(pct_quo, period_q);
				end
			end else if ((quotient == '0) || (quotient > DIV_W'(MAX_PERIOD_COUNTS))) begin
				status_d = ST_BAD_SETTING;
			end else begin
				period_d = 16'(quotient - DIV_W'(1));
			end
		end
	end

	// Output levels after the transaction
	always_comb begin
		pwm_d = '0;
		for (int c = 0; c < CHANNELS; c++)
			pwm_d[c] = en_d[c] && ((counter_d < cmp_d[c]) ^ low_d[c]);
	end

	assign result.status     = status_d;
	assign result.pwm_out    = pwm_d;
	assign result.count_now  = counter_d;
	assign result.period_now = period_d;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			presc_q   <= '0;
			period_q  <= RST_INIT_MOD;
			running_q <= 1'b0;
			en_q      <= '0;
			low_q     <= '0;
			for (int c = 0; c < CHANNELS; c++) cmp_q[c] <= '0;
		end else if (cmd.apply_now || cmd.apply_div) begin
			counter_q <= counter_d;
			presc_q   <= presc_d;
			period_q  <= period_d;
			running_q <= running_d;
			en_q      <= en_d;
			low_q     <= low_d;
			for (int c = 0; c < CHANNELS; c++) cmp_q[c] <= cmp_d[c];
		end
	end

	// Pending command for the divider or the percent scaling
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			pend_ch_q  <= in_data.channel;
			pend_pct_q <= (in_data.command == CMD_PCT);
			pct_prod_q <= pct_product;
		end
	end

	// Percent scaling finishes in the cycle after it starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pct_done_q <= 1'b0;
		else         pct_done_q <= cmd.start_div && pct_go;
	end

	// Configuration registers; the initial modulo is restored by every reset,
	// which is also the only place it is applied, so it needs no storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_clk_q    <= RST_SRC_CLK;
			presc_code_q <= RST_PRESCALE;
			clk_src_q    <= RST_CLK_SRC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SRC_CLK:  src_clk_q    <= cfg_data;
				CFG_PRESCALE: presc_code_q <= cfg_data[2:0];
				CFG_CLK_SRC:  clk_src_q    <= cfg_data[1:0];
				CFG_INIT_MOD: ;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/ept_ctrl.sv =====
// Controller state machine: accepts transactions and sequences divides.
`timescale 1ns / 1ps
module ept_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                skid_full,
	input  ept_pkg::dp_status_t status,
	output logic                in_ready,
	output ept_pkg::ctrl_cmd_t  cmd
);
	import ept_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;
	logic        accept;

	assign accept = in_valid && in_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept && status.needs_div) state_d = S_DIV;
			S_DIV:  if (status.div_done) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready      = 1'b0;
		cmd.start_div = 1'b0;
		cmd.apply_now = 1'b0;
		cmd.apply_div = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready      = !skid_full;
				cmd.start_div = in_valid && !skid_full && status.needs_div;
				cmd.apply_now = in_valid && !skid_full && !status.needs_div;
			end
			S_DIV: cmd.apply_div = status.div_done;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== design/ept_outbuf.sv =====
// Result register with one skid entry.
`timescale 1ns / 1ps
module ept_outbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ept_pkg::ept_out_t push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ept_pkg::ept_out_t out_data,
	output logic              skid_full
);
	import ept_pkg::*;

	ept_out_t out_q;
	ept_out_t skid_q;
	logic     out_valid_q;
	logic     skid_valid_q;
	logic     adv;

	// Output register may load this cycle
	assign adv = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) skid_q <= push_data;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign skid_full = skid_valid_q;

endmodule

// ===== design/edge_aligned_pwm_timer_core.sv =====
// Top level of the multi-channel edge-aligned PWM timer.
`timescale 1ns / 1ps
// Usage:
//  in_valid/in_ready/in_data carry one command transaction (tick, start, stop,
//  channel mode, duty counts, duty percent, frequency). Every transaction gives
//  exactly one result transaction on out_valid/out_ready/out_data with status,
//  the channel levels after the command, the counter and the period.
//  cfg_valid/cfg_ready/cfg_index/cfg_data write the configuration registers;
//  cfg_ready is always high and writes are expected only while the block idles.
//  A command that needs neither the divider nor the percent scaling has its
//  result registered as it is taken, and one such transaction per cycle is
//  sustained while the skid entry is free. A duty percent below 100 on a
//  valid channel is scaled by a multiply: in_ready is low for one cycle,
//  the product is registered, then scaled and the result registered. A
//  frequency command with a nonzero frequency and prescaled clock runs the
//  32-step radix-2 divider: in_ready stays low until its result is applied.
//  Reset clears the counter, prescaler, run flag and all channels, loads the
//  period with 65535 and the configuration with its defaults.
//  When the receiver stalls, one more result is kept in a skid entry; after
//  that in_ready drops until out_ready takes a result.
module edge_aligned_pwm_timer_core #(
	parameter int CHANNELS = ept_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  ept_pkg::ept_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output ept_pkg::ept_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import ept_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t dp_status;
	ept_out_t   result;
	logic       skid_full;
	logic       push;

	assign cfg_ready = 1'b1;
	assign push      = cmd.apply_now || cmd.apply_div;

	ept_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.skid_full (skid_full),
		.status    (dp_status),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	ept_datapath #(
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (dp_status),
		.result    (result),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ept_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (result),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.skid_full (skid_full)
	);

`ifndef SYNTH
	// a held skid entry always sits behind a valid output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full |-> out_valid)
		else $error("skid entry held without a valid output");

	// a result is never pushed into a full buffer
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !skid_full)
		else $error("result pushed into a full output buffer");

	// a transaction that starts a divide blocks further input
	a_div_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start_div |=> !in_ready)
		else $error("input accepted while the divider is busy");

	// at most one of start, apply now and apply divide result
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("conflicting controller commands");
`endif

endmodule

// ===== verif/ept_checker.sv =====
// Result checker for the PWM timer core: tracks the timer state and compares every result.
`timescale 1ns / 1ps
module ept_checker #(
	parameter int CHANNELS = ept_pkg::DEF_CHANNELS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  ept_pkg::ept_in_t              in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  ept_pkg::ept_out_t             out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ept_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data,
	output int                            mismatches,
	output int                            outstanding
);
	import ept_pkg::*;

	// Shadow copy of the configuration registers; the initial modulo only
	// matters at reset, where it always holds its default
	logic [31:0] src_hz;
	logic [2:0]  presc_code;
	logic [1:0]  clk_sel;

	// Shadow copy of the timer state
	logic [15:0] tmr_count;
	logic [6:0]  presc_count;
	logic [15:0] period_mod;
	logic        run_flag;
	logic        ch_en  [MAX_CHANNELS];
	logic        ch_low [MAX_CHANNELS];
	logic [15:0] ch_cmp [MAX_CHANNELS];

	// Results still owed by the block, oldest first
	ept_out_t    owed_results [$];
	ept_out_t    oldest;

	// Compare value limited to one past the period
	function automatic logic [15:0] clamp_duty(input logic [31:0] d);
		logic [31:0] ceiling;
		ceiling = {16'd0, period_mod} + 32'd1;
		return (d > ceiling) ? ceiling[15:0] : d[15:0];
	endfunction

	// Apply one command to the shadow state and return the result it must produce
	function automatic ept_out_t apply_command(input ept_in_t c);
		ept_out_t    r;
		logic [7:0]  wrap_at;
		logic [31:0] scaled;
		logic [31:0] counts;
		logic [31:0] want;
		logic        lvl;
		logic        ch_ok;
		r = '0;
		r.status = ST_OK;
		ch_ok = (c.channel < CHANNELS);
		case (c.command)
			CMD_TICK: begin
				if (run_flag) begin
					wrap_at = (8'd1 << presc_code) - 8'd1;
					// prescaler at or past its limit rolls over and moves the counter
					if ({1'b0, presc_count} >= wrap_at) begin
						presc_count = '0;
						tmr_count = (tmr_count >= period_mod) ? 16'd0 : tmr_count + 16'd1;
					end else begin
						presc_count = presc_count + 7'd1;
					end
				end
			end
			CMD_START: run_flag = (clk_sel != 2'd0);
			CMD_STOP: run_flag = 1'b0;
			CMD_MODE: begin
				if (!ch_ok) begin
					r.status = ST_BAD_CHANNEL;
				end else begin
					ch_en[c.channel] = 1'b1;
					ch_low[c.channel] = c.low_true_mode;
				end
			end
			CMD_DUTY: begin
				if (!ch_ok) begin
					r.status = ST_BAD_CHANNEL;
				end else begin
					ch_cmp[c.channel] = clamp_duty({16'd0, c.duty_counts});
				end
			end
			CMD_PCT: begin
				// channel range is checked before the percent range
				if (!ch_ok) begin
					r.status = ST_BAD_CHANNEL;
				end else if (c.duty_percent > PCT_FULL) begin
					r.status = ST_BAD_SETTING;
				end else begin
					if (c.duty_percent == PCT_FULL) begin
						want = (period_mod != MAX_16) ? {16'd0, period_mod} + 32'd1
							: {16'd0, period_mod};
					end else begin
						want = (({16'd0, period_mod} + 32'd1) * c.duty_percent) / PCT_FULL;
					end
					ch_cmp[c.channel] = clamp_duty(want);
				end
			end
			CMD_FREQ: begin
				scaled = src_hz >> presc_code;
				if (c.frequency_hz == 32'd0 || scaled == 32'd0) begin
					r.status = ST_BAD_SETTING;
				end else begin
					counts = scaled / c.frequency_hz;
					if (counts == 32'd0 || counts > MAX_PERIOD_COUNTS) begin
						r.status = ST_BAD_SETTING;
					end else begin
						period_mod = 16'(counts - 32'd1);
					end
				end
			end
			default: r.status = ST_BAD_SETTING;
		endcase

		// Channel levels after the command
		for (int i = 0; i < CHANNELS; i++) begin
			if (ch_en[i]) begin
				lvl = (tmr_count < ch_cmp[i]);
				r.pwm_out[i] = ch_low[i] ? !lvl : lvl;
			end
		end
		r.count_now = tmr_count;
		r.period_now = period_mod;
		return r;
	endfunction

	// Watch the three channels on every rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_hz = RST_SRC_CLK;
			presc_code = RST_PRESCALE;
			clk_sel = RST_CLK_SRC;
			tmr_count = '0;
			presc_count = '0;
			period_mod = RST_INIT_MOD;
			run_flag = 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				ch_en[i] = 1'b0;
				ch_low[i] = 1'b0;
				ch_cmp[i] = '0;
			end
			owed_results.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// register writes; the initial modulo and unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SRC_CLK: src_hz = cfg_data;
					CFG_PRESCALE: presc_code = cfg_data[2:0];
					CFG_CLK_SRC: clk_sel = cfg_data[1:0];
					default: ;
				endcase
			end

			// result transaction against the oldest owed result
			if (out_valid && out_ready) begin
				if (owed_results.size() == 0) begin
					if (mismatches < 10)
						$display("[%0t] result with none owed: st=%0d pwm=%h cnt=%0d per=%0d",
							$realtime, out_data.status, out_data.pwm_out,
							out_data.count_now, out_data.period_now);
					mismatches++;
				end else begin
					oldest = owed_results.pop_front();
					if (out_data.status !== oldest.status || out_data.pwm_out !== oldest.pwm_out
							|| out_data.count_now !== oldest.count_now
							|| out_data.period_now !== oldest.period_now) begin
						if (mismatches < 10)
							$display({"[%0t] mismatch: exp st=%0d pwm=%h cnt=%0d per=%0d",
								" got st=%0d pwm=%h cnt=%0d per=%0d"}, $realtime,
								oldest.status, oldest.pwm_out, oldest.count_now,
								oldest.period_now, out_data.status, out_data.pwm_out,
								out_data.count_now, out_data.period_now);
						mismatches++;
					end
				end
			end

			// command transaction: predict its result
			if (in_valid && in_ready)
				owed_results.push_back(apply_command(in_data));
			outstanding = owed_results.size();
		end
	end

endmodule

// ===== verif/edge_aligned_pwm_timer_core_test.sv =====
// Regression top for the PWM timer core: stimulus, handshake pacing and the verdict.
`timescale 1ns / 1ps
module edge_aligned_pwm_timer_core_test;
	import ept_pkg::*;

	localparam int CHANNELS = DEF_CHANNELS;
	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic [CFG_IDX_W-1:0] CFG_NEXT = 8'd4;    // first index past the registers
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = 8'hFF;
	localparam int HOLD_CYCLES = 250;
	localparam int PHASE_ITEMS = 236;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid;
	logic                 in_ready;
	ept_in_t              in_data;
	logic                 out_valid;
	logic                 out_ready;
	ept_out_t             out_data;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   mismatches;
	int                   outstanding;

	// Pacing knobs
	int                   send_idle_pct = 0;
	int                   recv_idle_pct = 0;
	int                   hold_requests = 0;
	int                   holds_done = 0;
	int                   hold_left = 0;

	// Hints for shaping frequency and duty values
	logic [31:0]          scaled_clk = RST_SRC_CLK;
	int                   span_hint = 16;

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	edge_aligned_pwm_timer_core #(
		.CHANNELS(CHANNELS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ept_checker #(
		.CHANNELS(CHANNELS)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Result side: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Offer one command transaction and wait until it is taken
	task automatic send_item(input ept_in_t it);
		int gap;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 4);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// Command with every unused field random
	function automatic ept_in_t filler(input logic [2:0] cmd, input logic [3:0] ch);
		ept_in_t it;
		it.command = cmd;
		it.channel = ch;
		it.low_true_mode = 1'($urandom_range(1));
		it.duty_counts = 16'($urandom);
		it.duty_percent = 8'($urandom);
		it.frequency_hz = $urandom;
		return it;
	endfunction

	function automatic logic [3:0] pick_channel();
		if ($urandom_range(9) == 0)
			return 4'($urandom_range(15, CHANNELS));
		return 4'($urandom_range(CHANNELS - 1));
	endfunction

	task automatic send_cmd(input logic [2:0] cmd);
		send_item(filler(cmd, 4'($urandom_range(15))));
	endtask

	task automatic send_mode(input logic [3:0] ch, input logic lt);
		ept_in_t it;
		it = filler(CMD_MODE, ch);
		it.low_true_mode = lt;
		send_item(it);
	endtask

	task automatic send_duty(input logic [3:0] ch, input logic [15:0] counts);
		ept_in_t it;
		it = filler(CMD_DUTY, ch);
		it.duty_counts = counts;
		send_item(it);
	endtask

	task automatic send_pct(input logic [3:0] ch, input logic [7:0] pct);
		ept_in_t it;
		it = filler(CMD_PCT, ch);
		it.duty_percent = pct;
		send_item(it);
	endtask

	task automatic send_freq(input logic [31:0] hz);
		ept_in_t it;
		it = filler(CMD_FREQ, 4'($urandom_range(15)));
		it.frequency_hz = hz;
		send_item(it);
	endtask

	// Register write; cfg_valid is dropped again before the task returns
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input logic [31:0] src, input logic [2:0] pre,
			input logic [1:0] sel, input logic [15:0] imod);
		write_reg(CFG_SRC_CLK, src);
		write_reg(CFG_PRESCALE, {29'd0, pre});
		write_reg(CFG_CLK_SRC, {30'd0, sel});
		write_reg(CFG_INIT_MOD, {16'd0, imod});
		scaled_clk = src >> pre;
	endtask

	// Stop offering and wait for every owed result
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Mostly ticks, with channel and period updates mixed in and a little noise
	function automatic ept_in_t random_item();
		ept_in_t it;
		int      roll;
		int      k;
		roll = $urandom_range(99);
		it = filler(CMD_TICK, pick_channel());
		if (roll < 52) begin
			it.command = CMD_TICK;
		end else if (roll < 56) begin
			it.command = CMD_START;
		end else if (roll < 59) begin
			it.command = CMD_STOP;
		end else if (roll < 67) begin
			it.command = CMD_MODE;
		end else if (roll < 77) begin
			it.command = CMD_DUTY;
			if ($urandom_range(3) != 0)
				it.duty_counts = 16'($urandom_range(span_hint + 2));
		end else if (roll < 86) begin
			it.command = CMD_PCT;
			if ($urandom_range(7) != 0)
				it.duty_percent = 8'($urandom_range(100));
		end else if (roll < 93) begin
			it.command = CMD_FREQ;
			k = ($urandom_range(5) == 0) ? $urandom_range(1, 70000) : $urandom_range(1, 40);
			case ($urandom_range(9))
				0: it.frequency_hz = $urandom;
				1: it.frequency_hz = 32'd0;
				default: begin
					it.frequency_hz = scaled_clk / k;
					span_hint = k;
				end
			endcase
		end else begin
			it.command = 3'($urandom_range(7));
			it.channel = 4'($urandom_range(15));
		end
		return it;
	endfunction

	// One configuration setting: short period, running, a few channels, then random traffic
	task automatic run_phase(input logic [31:0] src, input logic [2:0] pre,
			input logic [1:0] sel, input logic [15:0] imod, input bit with_hold);
		int          k;
		int          n;
		logic [3:0]  ch;
		set_timing(src, pre, sel, imod);
		k = $urandom_range(1, 24);
		span_hint = k;
		send_freq(scaled_clk / k);
		send_cmd(CMD_START);
		for (n = 0; n < 3; n++) begin
			ch = 4'($urandom_range(CHANNELS - 1));
			send_mode(ch, 1'($urandom_range(1)));
			send_duty(ch, 16'($urandom_range(k + 1)));
		end
		for (n = 8; n < PHASE_ITEMS; n++) begin
			// receiver holds off while commands keep coming
			if (with_hold && n == 40)
				hold_requests <= hold_requests + 1;
			if (n == PHASE_ITEMS / 2)
				drain();
			send_item(random_item());
		end
		drain();
	endtask

	// Run limit
	initial begin
		#2000000;
		$display("edge_aligned_pwm_timer_core regression: fail");
		$finish;
	end

	initial begin
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: range checks, rejected settings and a wrap after the period shrinks
		send_cmd(CMD_TICK);
		send_mode(4'd15, 1'b1);
		send_duty(4'd8, 16'h1234);
		send_pct(4'd9, 8'd200);
		send_pct(4'd0, 8'd101);
		send_pct(4'd7, 8'd255);
		send_cmd(CMD_UNUSED);
		send_pct(4'd0, 8'd100);
		send_duty(4'd1, 16'hFFFF);
		send_mode(4'd0, 1'b0);
		send_mode(4'd1, 1'b1);
		send_freq(32'd0);
		send_freq(32'hFFFF_FFFF);
		send_freq(32'd100);
		send_cmd(CMD_START);
		repeat (5) send_cmd(CMD_TICK);
		send_freq(32'd2000000);
		send_cmd(CMD_TICK);
		send_duty(4'd1, 16'hFFFF);
		send_pct(4'd2, 8'd100);
		send_pct(4'd3, 8'd50);
		send_mode(4'd2, 1'b0);
		send_mode(4'd3, 1'b1);
		send_cmd(CMD_STOP);
		send_cmd(CMD_TICK);
		drain();

		// Directed: clock select, prescaler rollover and the period limits
		write_reg(CFG_CLK_SRC, 32'd0);
		send_cmd(CMD_START);
		send_cmd(CMD_TICK);
		drain();
		write_reg(CFG_CLK_SRC, 32'd3);
		write_reg(CFG_PRESCALE, 32'd7);
		write_reg(CFG_SRC_CLK, 32'd65536);
		send_cmd(CMD_START);
		repeat (3) send_cmd(CMD_TICK);
		drain();
		write_reg(CFG_PRESCALE, 32'd0);
		send_cmd(CMD_TICK);
		send_freq(32'd1);
		drain();
		write_reg(CFG_SRC_CLK, 32'd65537);
		send_freq(32'd1);
		drain();
		write_reg(CFG_SRC_CLK, 32'd1);
		write_reg(CFG_PRESCALE, 32'd1);
		send_freq(32'd5);
		drain();
		write_reg(CFG_INIT_MOD, 32'd0);
		write_reg(CFG_NEXT, 32'hFFFF_FFFF);
		write_reg(CFG_NONE, 32'd0);
		send_cmd(CMD_TICK);
		drain();

		// Random: sender idles lightly, receiver heavily
		send_idle_pct = 15;
		recv_idle_pct <= 60;
		run_phase(32'hFFFF_FFFF, 3'd7, 2'd3, 16'd0, 1'b1);
		run_phase(32'd1, 3'd0, 2'd1, 16'hFFFF, 1'b0);

		// Random: the other way round
		send_idle_pct = 60;
		recv_idle_pct <= 15;
		run_phase(32'd8000000, 3'd2, 2'd2, 16'($urandom), 1'b0);
		run_phase($urandom, 3'($urandom_range(3)), 2'($urandom_range(1, 3)),
			16'($urandom), 1'b0);

		// Random: no idling
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		run_phase(32'd65536, 3'd0, 2'd1, 16'($urandom), 1'b1);
		run_phase($urandom, 3'd1, 2'($urandom_range(1, 3)), 16'($urandom), 1'b0);

		repeat (40) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("edge_aligned_pwm_timer_core regression: pass");
		end else begin
			$display("edge_aligned_pwm_timer_core regression: fail");
		end
		$finish;
	end

endmodule
